// ----- rtl/tom_pkg.sv -----
// Package with the shared constants of the 2-opt length change block.
`timescale 1ns / 1ps
`default_nettype none
package tom_pkg;
  localparam int unsigned COORD_BITS_DEF = 24;
  localparam int unsigned OUT_BITS = 23;
  localparam int unsigned NUM_LANES = 4;
endpackage
`default_nettype wire

// ----- rtl/two_opt_move_delta.sv -----
// Top level of the 2-opt move length change engine.
// Each accepted word passes through the lane registers and then the merge output register.
// Throughput: one word per cycle while not stalled; four distance lanes run side by side.
// The square root pipeline in each lane produces one root bit per stage.
// The whole pipeline holds only while a finished result is stalled.
// Reset clears the valid pipeline; data registers are not reset.
`timescale 1ns / 1ps
`default_nettype none
module two_opt_move_delta import tom_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         valid_i,
  output logic                              stall_o,
  input  wire logic signed [COORD_BITS-1:0] a_x_i,
  input  wire logic signed [COORD_BITS-1:0] a_y_i,
  input  wire logic signed [COORD_BITS-1:0] b_x_i,
  input  wire logic signed [COORD_BITS-1:0] b_y_i,
  input  wire logic signed [COORD_BITS-1:0] c_x_i,
  input  wire logic signed [COORD_BITS-1:0] c_y_i,
  input  wire logic signed [COORD_BITS-1:0] d_x_i,
  input  wire logic signed [COORD_BITS-1:0] d_y_i,
  output logic                              valid_o,
  input  wire logic                         stall_i,
  output logic signed [OUT_BITS-1:0]        length_change_o
);
  localparam int unsigned RW = COORD_BITS + 1;
  localparam int unsigned DSW = RW - 2;
  localparam int unsigned LAT = RW + 5;

  logic en;
  logic [LAT-1:0] vld_q, vld_d;
  logic [DSW-1:0] d_ac, d_bd, d_ab, d_cd;

  assign en = !(vld_q[LAT-1] && stall_i);
  assign stall_o = !en;
  assign vld_d = {vld_q[LAT-2:0], valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= vld_d;
    end
  end

  tom_lane #(.COORD_BITS(COORD_BITS)) u_ac (.clk_i, .en_i(en), .px_i(a_x_i), .py_i(a_y_i),
    .qx_i(c_x_i), .qy_i(c_y_i), .dist_o(d_ac));
  tom_lane #(.COORD_BITS(COORD_BITS)) u_bd (.clk_i, .en_i(en), .px_i(b_x_i), .py_i(b_y_i),
    .qx_i(d_x_i), .qy_i(d_y_i), .dist_o(d_bd));
  tom_lane #(.COORD_BITS(COORD_BITS)) u_ab (.clk_i, .en_i(en), .px_i(a_x_i), .py_i(a_y_i),
    .qx_i(b_x_i), .qy_i(b_y_i), .dist_o(d_ab));
  tom_lane #(.COORD_BITS(COORD_BITS)) u_cd (.clk_i, .en_i(en), .px_i(c_x_i), .py_i(c_y_i),
    .qx_i(d_x_i), .qy_i(d_y_i), .dist_o(d_cd));

  tom_merge #(.DSW(DSW)) u_merge (.clk_i, .en_i(en), .ac_i(d_ac), .bd_i(d_bd),
    .ab_i(d_ab), .cd_i(d_cd), .delta_o(length_change_o));

  assign valid_o = vld_q[LAT-1];
endmodule
`default_nettype wire

// ----- rtl/tom_lane.sv -----
// One distance lane: difference, squares, sum, pipelined square root and rounding.
`timescale 1ns / 1ps
`default_nettype none
module tom_lane import tom_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF,
  localparam int unsigned RW = COORD_BITS + 1,
  localparam int unsigned DSW = RW - 2
) (
  input  wire logic                         clk_i,
  input  wire logic                         en_i,
  input  wire logic signed [COORD_BITS-1:0] px_i,
  input  wire logic signed [COORD_BITS-1:0] py_i,
  input  wire logic signed [COORD_BITS-1:0] qx_i,
  input  wire logic signed [COORD_BITS-1:0] qy_i,
  output logic             [DSW-1:0]        dist_o
);
  localparam int unsigned CB = COORD_BITS;
  localparam int unsigned RMW = RW + 2;

  logic signed [CB:0] ex, ey;
  logic [CB-1:0] dx_q, dy_q;
  logic [2*CB-1:0] sx_q, sy_q;
  logic [2*RW-1:0] rad_q [RW+1];
  logic [RMW-1:0] rem_q [RW+1];
  logic [RW-1:0] root_q [RW+1];
  logic [DSW-1:0] dist_q;

  assign ex = {px_i[CB-1], px_i} - {qx_i[CB-1], qx_i};
  assign ey = {py_i[CB-1], py_i} - {qy_i[CB-1], qy_i};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dx_q <= ex[CB] ? CB'(-ex) : ex[CB-1:0];
      dy_q <= ey[CB] ? CB'(-ey) : ey[CB-1:0];
      sx_q <= dx_q * dx_q;
      sy_q <= dy_q * dy_q;
      rad_q[0] <= {1'b0, {1'b0, sx_q} + {1'b0, sy_q}};
      rem_q[0] <= '0;
      root_q[0] <= '0;
    end
  end

  for (genvar k = 0; k < RW; k++) begin : g_step
    logic [RMW-1:0] cur, trial;
    assign cur = {rem_q[k][RMW-3:0], rad_q[k][2*RW-1 -: 2]};
    assign trial = {root_q[k], 2'b01};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[k+1] <= {rad_q[k][2*RW-3:0], 2'b00};
        if (cur >= trial) begin
          rem_q[k+1] <= cur - trial;
          root_q[k+1] <= {root_q[k][RW-2:0], 1'b1};
        end else begin
          rem_q[k+1] <= cur;
          root_q[k+1] <= {root_q[k][RW-2:0], 1'b0};
        end
      end
    end
  end

  logic [DSW:0] rnd;
  assign rnd = {2'b00, root_q[RW][RW-1:3]} + (DSW+1)'(1);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dist_q <= rnd[DSW:1];
    end
  end

  assign dist_o = dist_q;
endmodule
`default_nettype wire

// ----- rtl/tom_merge.sv -----
// Merging stage: new minus old length, saturated into the output register.
`timescale 1ns / 1ps
`default_nettype none
module tom_merge import tom_pkg::*; #(
  parameter int unsigned DSW = COORD_BITS_DEF - 1
) (
  input  wire logic                       clk_i,
  input  wire logic                       en_i,
  input  wire logic        [DSW-1:0]      ac_i,
  input  wire logic        [DSW-1:0]      bd_i,
  input  wire logic        [DSW-1:0]      ab_i,
  input  wire logic        [DSW-1:0]      cd_i,
  output logic signed      [OUT_BITS-1:0] delta_o
);
  localparam int unsigned DW = (DSW + 2 > OUT_BITS + 1) ? DSW + 2 : OUT_BITS + 1;
  localparam logic signed [DW-1:0] MAXV = DW'((1 << (OUT_BITS - 1)) - 1);
  localparam logic signed [DW-1:0] MINV = -DW'(1 << (OUT_BITS - 1));

  logic signed [DW-1:0] nl, ol, dl;
  logic signed [OUT_BITS-1:0] delta_q;

  assign nl = signed'(DW'(ac_i)) + signed'(DW'(bd_i));
  assign ol = signed'(DW'(ab_i)) + signed'(DW'(cd_i));
  assign dl = nl - ol;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (dl > MAXV) delta_q <= MAXV[OUT_BITS-1:0];
      else if (dl < MINV) delta_q <= MINV[OUT_BITS-1:0];
      else delta_q <= dl[OUT_BITS-1:0];
    end
  end

  assign delta_o = delta_q;
endmodule
`default_nettype wire

// ----- rtl/tom_checker.sv -----
// Port checker for the 2-opt move length change engine, with its bind.
`timescale 1ns / 1ps
`default_nettype none
module tom_checker import tom_pkg::*; (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                stall_o,
  input wire logic                valid_o,
  input wire logic                stall_i,
  input wire logic [OUT_BITS-1:0] length_change_o
);
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> (valid_o && stall_i)) else $error("stall without a held result");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && stall_i) |=> (valid_o && $stable(length_change_o)))
    else $error("stalled result word changed");
  a_reset: assert property (@(posedge clk_i) !rst_ni |=> !valid_o)
    else $error("result word valid after reset");
  a_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !valid_o |-> !stall_o) else $error("input stalled with empty output");
endmodule

bind two_opt_move_delta tom_checker u_tom_checker (.clk_i, .rst_ni, .stall_o,
  .valid_o, .stall_i, .length_change_o);
`default_nettype wire
